/* hdl/tsq_pkg.sv */
package tsq_pkg;

  // Field widths of one request, of one stored cell and of the result status and count.
  localparam int unsigned ID_W    = 8;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned ENTRY_W = TIME_W + ID_W;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 5;

  // Operation codes on the request channel.
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  // Status codes on the result channel.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_PUSH_FULL  = 2'd1,
    STAT_POP_EMPTY  = 2'd2
  } stat_t;

  // Controller states: whether a finished result is waiting to be taken.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_HOLD = 1'b1
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  push;      // insert the request in order
    logic  pop;       // remove the head
    logic  load;      // capture the result registers
    stat_t status;    // status code for the result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

/* hdl/tsq_ctrl.sv */
module tsq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_op,
  output logic             out_valid,
  input  logic             out_ready,
  input  tsq_pkg::dp_stat_t dp_stat,
  output tsq_pkg::dp_cmd_t  dp_cmd
);
  import tsq_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic        accept;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A new request is taken whenever the result register is free or being emptied.
  always_comb begin
    out_valid = (state_r == ST_HOLD);
    in_ready  = (state_r == ST_IDLE) || out_ready;
    accept    = in_valid && in_ready;

    dp_cmd        = '0;
    dp_cmd.load   = accept;
    dp_cmd.status = STAT_OK;
    if (accept) begin
      if (op_t'(in_op) == OP_PUSH) begin
        if (dp_stat.full) begin
          dp_cmd.status = STAT_PUSH_FULL;
        end else begin
          dp_cmd.push = 1'b1;
        end
      end else begin
        if (dp_stat.empty) begin
          dp_cmd.status = STAT_POP_EMPTY;
        end else begin
          dp_cmd.pop = 1'b1;
        end
      end
    end

    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!accept && out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/tsq_datapath.sv */
module tsq_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tsq_pkg::ID_W-1:0]      in_source_id,
  input  logic [tsq_pkg::TIME_W-1:0]    in_request_time,
  input  tsq_pkg::dp_cmd_t              dp_cmd,
  output tsq_pkg::dp_stat_t             dp_stat,
  output logic [tsq_pkg::STAT_W-1:0]    out_status,
  output logic [tsq_pkg::ID_W-1:0]      out_popped_id,
  output logic [tsq_pkg::TIME_W-1:0]    out_popped_time,
  output logic [tsq_pkg::ID_W-1:0]      out_head_id,
  output logic [tsq_pkg::TIME_W-1:0]    out_head_time,
  output logic [tsq_pkg::COUNT_W-1:0]   out_entry_count,
  output logic                          out_is_empty_flag
);
  import tsq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Sorted cells, head at cell 0, each {time, id} so plain compare gives queue order.
  logic [ENTRY_W-1:0] cell_r   [DEPTH];
  logic [ENTRY_W-1:0] cell_nxt [DEPTH];
  logic [CNT_W-1:0]   occ_r;
  logic [CNT_W-1:0]   occ_nxt;
  logic [DEPTH-1:0]   keep;
  logic [ENTRY_W-1:0] new_entry;
  logic [ENTRY_W-1:0] head_nxt;
  logic [31:0]        occ_ext;

  // Result registers.
  logic [STAT_W-1:0]  status_r;
  logic [ENTRY_W-1:0] popped_r;
  logic [ENTRY_W-1:0] head_r;
  logic [COUNT_W-1:0] count_r;
  logic               empty_r;

  assign new_entry     = {in_request_time, in_source_id};
  assign dp_stat.full  = (occ_r == CNT_W'(DEPTH));
  assign dp_stat.empty = (occ_r == '0);

  // Every cell compares itself with the new request at once; the held cells that
  // order at or before it form an unbroken run from the head.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      keep[i] = (CNT_W'(i) < occ_r) && (cell_r[i] <= new_entry);
    end
  end

  // Next cell contents: insert shifts the tail back by one, pop shifts forward.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_nxt[i] = cell_r[i];
      if (dp_cmd.push) begin
        if (!keep[i]) begin
          if (i == 0) begin
            cell_nxt[i] = new_entry;
          end else if (keep[i-1]) begin
            cell_nxt[i] = new_entry;
          end else begin
            cell_nxt[i] = cell_r[i-1];
          end
        end
      end else if (dp_cmd.pop) begin
        if (i < DEPTH - 1) begin
          cell_nxt[i] = cell_r[i+1];
        end
      end
    end

    occ_nxt = occ_r;
    if (dp_cmd.push) begin
      occ_nxt = occ_r + CNT_W'(1);
    end else if (dp_cmd.pop) begin
      occ_nxt = occ_r - CNT_W'(1);
    end

    head_nxt = (occ_nxt != '0) ? cell_nxt[0] : '0;
    occ_ext  = 32'(occ_nxt);
  end

  // Cell storage and occupancy count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  // Capture the result of each accepted request.
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      status_r <= dp_cmd.status;
      popped_r <= dp_cmd.pop ? cell_r[0] : '0;
      head_r   <= head_nxt;
      count_r  <= occ_ext[COUNT_W-1:0];
      empty_r  <= (occ_nxt == '0);
    end
  end

  assign out_status        = status_r;
  assign out_popped_id     = popped_r[ID_W-1:0];
  assign out_popped_time   = popped_r[ENTRY_W-1:ID_W];
  assign out_head_id       = head_r[ID_W-1:0];
  assign out_head_time     = head_r[ENTRY_W-1:ID_W];
  assign out_entry_count   = count_r;
  assign out_is_empty_flag = empty_r;

endmodule

/* hdl/timestamp_ordered_request_queue_core.sv */
// Channel   | Direction | Handshake          | Payload
// in_       | input     | in_valid/in_ready   | op, source_id, request_time
// out_      | output    | out_valid/out_ready | status, popped_id/time, head_id/time,
//           |           |                     | entry_count, is_empty_flag
//
// Each request is executed in the cycle it is accepted by a row of cells that all
// compare against it in parallel; its result appears in the output register next cycle.
// One request per cycle is sustained while the result side keeps taking results.
// Synchronous active-low reset empties the queue and drops any waiting result.
// While a result waits unaccepted, in_ready follows out_ready.
module timestamp_ordered_request_queue_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [tsq_pkg::ID_W-1:0]    in_source_id,
  input  logic [tsq_pkg::TIME_W-1:0]  in_request_time,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tsq_pkg::STAT_W-1:0]  out_status,
  output logic [tsq_pkg::ID_W-1:0]    out_popped_id,
  output logic [tsq_pkg::TIME_W-1:0]  out_popped_time,
  output logic [tsq_pkg::ID_W-1:0]    out_head_id,
  output logic [tsq_pkg::TIME_W-1:0]  out_head_time,
  output logic [tsq_pkg::COUNT_W-1:0] out_entry_count,
  output logic                        out_is_empty_flag
);
  import tsq_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Handshake and command control.
  tsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  // Sorted cell row and result registers.
  tsq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_source_id      (in_source_id),
    .in_request_time   (in_request_time),
    .dp_cmd            (dp_cmd),
    .dp_stat           (dp_stat),
    .out_status        (out_status),
    .out_popped_id     (out_popped_id),
    .out_popped_time   (out_popped_time),
    .out_head_id       (out_head_id),
    .out_head_time     (out_head_time),
    .out_entry_count   (out_entry_count),
    .out_is_empty_flag (out_is_empty_flag)
  );

endmodule

/* verif/tsq_outcome_checker.sv */
// Watches both channels of the request queue, keeps its own sorted copy of the
// held requests and checks every result against the outcome it predicts.
module tsq_outcome_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 in_op,
  input  logic [tsq_pkg::ID_W-1:0]             in_source_id,
  input  logic [tsq_pkg::TIME_W-1:0]           in_request_time,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic [tsq_pkg::STAT_W-1:0]           out_status,
  input  logic [tsq_pkg::ID_W-1:0]             out_popped_id,
  input  logic [tsq_pkg::TIME_W-1:0]           out_popped_time,
  input  logic [tsq_pkg::ID_W-1:0]             out_head_id,
  input  logic [tsq_pkg::TIME_W-1:0]           out_head_time,
  input  logic [tsq_pkg::COUNT_W-1:0]          out_entry_count,
  input  logic                                 out_is_empty_flag,
  output int                                   mismatches,
  output int                                   outstanding,
  output int                                   full_drops,
  output int                                   empty_pops
);

  import tsq_pkg::*;

  // One predicted result of a request.
  typedef struct packed {
    stat_t               status;
    logic [ID_W-1:0]     popped_id;
    logic [TIME_W-1:0]   popped_time;
    logic [ID_W-1:0]     head_id;
    logic [TIME_W-1:0]   head_time;
    logic [COUNT_W-1:0]  entry_count;
    logic                no_entries;
  } queue_outcome_t;

  // Sorted copy of the queue: cell 0 is the head, each cell is {time, id}.
  logic [ENTRY_W-1:0] held_cells [DEPTH];
  int unsigned        held_count;
  queue_outcome_t     awaited_outcomes[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    full_drops  = 0;
    empty_pops  = 0;
    held_count  = 0;
  end

  // Applies one request to the copy of the queue and returns what the block
  // should report for it.
  function automatic queue_outcome_t apply_request(logic op, logic [ID_W-1:0] id,
                                                   logic [TIME_W-1:0] stamp);
    queue_outcome_t     res;
    logic [ENTRY_W-1:0] incoming;
    logic [ENTRY_W-1:0] removed;
    int unsigned        pos;
    res      = '0;
    res.status = STAT_OK;
    removed  = '0;
    incoming = {stamp, id};
    if (op == OP_PUSH) begin
      if (held_count >= DEPTH) begin
        res.status = STAT_PUSH_FULL;
      end else begin
        // An equal request already held stays in front of the new one.
        pos = 0;
        while (pos < held_count && held_cells[pos] <= incoming) pos++;
        for (int unsigned i = held_count; i > pos; i--) held_cells[i] = held_cells[i-1];
        held_cells[pos] = incoming;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = STAT_POP_EMPTY;
      end else begin
        removed = held_cells[0];
        for (int unsigned i = 1; i < held_count; i++) held_cells[i-1] = held_cells[i];
        held_count--;
      end
    end
    res.popped_id   = removed[ID_W-1:0];
    res.popped_time = removed[ENTRY_W-1:ID_W];
    if (held_count != 0) begin
      res.head_id   = held_cells[0][ID_W-1:0];
      res.head_time = held_cells[0][ENTRY_W-1:ID_W];
    end
    res.entry_count = held_count[COUNT_W-1:0];
    res.no_entries  = (held_count == 0);
    return res;
  endfunction

  // Results are checked before the request of the same edge is predicted;
  // a result always belongs to an earlier request.
  always @(posedge clk) begin
    queue_outcome_t want;
    queue_outcome_t seen;
    if (!rst_n) begin
      held_count = 0;
      awaited_outcomes.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen = '{stat_t'(out_status), out_popped_id, out_popped_time, out_head_id,
                 out_head_time, out_entry_count, out_is_empty_flag};
        if (awaited_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result with no request waiting: %p", $realtime, seen);
        end else begin
          want = awaited_outcomes.pop_front();
          if (seen.status !== want.status || seen.popped_id !== want.popped_id ||
              seen.popped_time !== want.popped_time || seen.head_id !== want.head_id ||
              seen.head_time !== want.head_time || seen.entry_count !== want.entry_count ||
              seen.no_entries !== want.no_entries) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] result differs\n  expected %p\n  actual   %p",
                       $realtime, want, seen);
          end
        end
      end
      if (in_valid && in_ready) begin
        want = apply_request(in_op, in_source_id, in_request_time);
        if (want.status == STAT_PUSH_FULL) full_drops++;
        if (want.status == STAT_POP_EMPTY) empty_pops++;
        awaited_outcomes.push_back(want);
      end
    end
    outstanding = awaited_outcomes.size();
  end

endmodule

/* verif/timestamp_ordered_request_queue_core_test.sv */
// Drives requests into the queue and takes its results, both with random
// pauses; the checker beside the block decides whether each result is right.
module timestamp_ordered_request_queue_core_test;

  import tsq_pkg::*;

  localparam int unsigned DEPTH         = 16;
  localparam int          RANDOM_ITEMS  = 1080;
  localparam int          HOLD_CYCLES   = 80;
  localparam int          DRAIN_CYCLES  = 8;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_op;
  logic [ID_W-1:0]      in_source_id;
  logic [TIME_W-1:0]    in_request_time;
  logic                 out_valid;
  logic                 out_ready;
  logic [STAT_W-1:0]    out_status;
  logic [ID_W-1:0]      out_popped_id;
  logic [TIME_W-1:0]    out_popped_time;
  logic [ID_W-1:0]      out_head_id;
  logic [TIME_W-1:0]    out_head_time;
  logic [COUNT_W-1:0]   out_entry_count;
  logic                 out_is_empty_flag;

  int mismatches;
  int outstanding;
  int full_drops;
  int empty_pops;
  int pushes_sent;
  int pops_sent;
  bit send_burst;
  bit hold_off_due;

  timestamp_ordered_request_queue_core #(.DEPTH(DEPTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_source_id      (in_source_id),
    .in_request_time   (in_request_time),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_popped_id     (out_popped_id),
    .out_popped_time   (out_popped_time),
    .out_head_id       (out_head_id),
    .out_head_time     (out_head_time),
    .out_entry_count   (out_entry_count),
    .out_is_empty_flag (out_is_empty_flag)
  );

  tsq_outcome_checker #(.DEPTH(DEPTH)) outcome_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_source_id      (in_source_id),
    .in_request_time   (in_request_time),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_popped_id     (out_popped_id),
    .out_popped_time   (out_popped_time),
    .out_head_id       (out_head_id),
    .out_head_time     (out_head_time),
    .out_entry_count   (out_entry_count),
    .out_is_empty_flag (out_is_empty_flag),
    .mismatches        (mismatches),
    .outstanding       (outstanding),
    .full_drops        (full_drops),
    .empty_pops        (empty_pops)
  );

  // Free-running clock, period 10.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("Timed out with %0d results still awaited", outstanding);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offers one request after a random pause, or at once in a burst, and waits until it is taken.
  // In_ready is sampled mid-cycle, where nothing changes before the next edge.
  task automatic offer_request(op_t op, logic [ID_W-1:0] id, logic [TIME_W-1:0] stamp);
    int gap;
    bit taken;
    gap = send_burst ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_source_id    <= id;
    in_request_time <= stamp;
    if (op == OP_PUSH) pushes_sent++;
    else pops_sent++;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Result side: random pauses, bursts with none, and one long hold-off.
  initial begin
    int gap;
    int taken_count;
    bit ok;
    bit rx_burst;
    out_ready   = 1'b0;
    taken_count = 0;
    rx_burst    = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (taken_count % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      gap = rx_burst ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        ok = out_valid;
        @(posedge clk);
      end while (!ok);
      taken_count++;
    end
  end

  // Request stream and verdict.
  initial begin
    int push_pct;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] stamp;
    in_valid        = 1'b0;
    in_op           = OP_PUSH;
    in_source_id    = '0;
    in_request_time = '0;
    rst_n           = 1'b0;
    pushes_sent     = 0;
    pops_sent       = 0;
    send_burst      = 1'b0;
    hold_off_due    = 1'b0;
    push_pct        = 50;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pop on an empty queue, extreme fields, ties and duplicates.
    offer_request(OP_POP, 8'h00, 16'h0000);
    offer_request(OP_PUSH, 8'hFF, 16'hFFFF);
    offer_request(OP_PUSH, 8'h00, 16'h0000);
    offer_request(OP_PUSH, 8'h05, 16'h1234);
    offer_request(OP_PUSH, 8'h05, 16'h1234);
    offer_request(OP_PUSH, 8'h04, 16'h1234);
    offer_request(OP_PUSH, 8'h06, 16'h1234);
    // Fill the queue, then push once more so the request is dropped.
    for (int i = 0; i < DEPTH - 6; i++)
      offer_request(OP_PUSH, 8'($urandom), 16'($urandom));
    offer_request(OP_PUSH, 8'hAA, 16'h0001);
    offer_request(OP_POP, 8'hFF, 16'hFFFF);
    offer_request(OP_POP, 8'h00, 16'h0000);

    // Random: phases lean towards pushes or pops, or hold them even, so the queue swings
    // between full and empty; small fields give plenty of ties.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 85;
          1: push_pct = 50;
          default: push_pct = 15;
        endcase
        send_burst = ($urandom_range(0, 3) == 0);
      end
      if (n == 400) hold_off_due = 1'b1;
      id    = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      stamp = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
      offer_request(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP, id, stamp);
    end
    in_valid <= 1'b0;

    // Let every awaited result arrive, then watch for strays. The first edge
    // makes sure the checker has counted the last request.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pushes and %0d pops with random pauses on both sides.",
             pushes_sent, pops_sent);
    $display("%0d pushes met a full queue and %0d pops an empty one.",
             full_drops, empty_pops);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, outstanding);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* timestamp_ordered_request_queue_core.f */
hdl/tsq_pkg.sv
hdl/tsq_ctrl.sv
hdl/tsq_datapath.sv
hdl/timestamp_ordered_request_queue_core.sv
verif/tsq_outcome_checker.sv
verif/timestamp_ordered_request_queue_core_test.sv
